/* rtl/core/fss_pkg.sv */
// Package for the fringe signal synthesizer: payload structs, register codes,
// queue status and the fixed-point cosine used to build the table at elaboration.
// No dependencies.
package fss_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;
  localparam logic [63:0] TwoPiQ30      = 64'd6746518852;
  localparam logic [63:0] OneQ30        = 64'd1073741824;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgStartPhase = 2'd0,
    CfgStepSize   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic               first;
    logic [15:0]        frequency;
    logic signed [15:0] background;
    logic [14:0]        amplitude;
    logic signed [15:0] noise;
  } fss_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clipped;
    logic [31:0]        phase_now;
  } fss_out_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [15:0] background;
    logic [14:0]        amplitude;
    logic signed [15:0] noise;
  } fss_work_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fss_qstat_t;

  function automatic logic [63:0] next_term(input logic [63:0] term, input logic [63:0] t2);
    return (term * t2) >> 30;
  endfunction

  function automatic logic signed [15:0] cos_turn(input logic [31:0] p);
    logic [63:0]        w;
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        q15;
    logic signed [63:0] acc;
    logic signed [15:0] mag;
    logic               use_sin;
    logic               neg;
    use_sin = p[30];
    neg     = p[31] ^ p[30];
    w       = {34'd0, p[29:0]};
    if (w > 64'd536870912) begin
      w       = 64'd1073741824 - w;
      use_sin = !use_sin;
    end
    t  = (w * TwoPiQ30 + 64'd2147483648) >> 32;
    t2 = (t * t) >> 30;
    if (use_sin) begin
      term = t;
      acc  = $signed(term);
      term = next_term(term, t2) / 64'd6;
      acc  = acc - $signed(term);
      term = next_term(term, t2) / 64'd20;
      acc  = acc + $signed(term);
      term = next_term(term, t2) / 64'd42;
      acc  = acc - $signed(term);
      term = next_term(term, t2) / 64'd72;
      acc  = acc + $signed(term);
      term = next_term(term, t2) / 64'd110;
      acc  = acc - $signed(term);
    end else begin
      term = OneQ30;
      acc  = $signed(term);
      term = next_term(term, t2) / 64'd2;
      acc  = acc - $signed(term);
      term = next_term(term, t2) / 64'd12;
      acc  = acc + $signed(term);
      term = next_term(term, t2) / 64'd30;
      acc  = acc - $signed(term);
      term = next_term(term, t2) / 64'd56;
      acc  = acc + $signed(term);
      term = next_term(term, t2) / 64'd90;
      acc  = acc - $signed(term);
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    q15 = ($unsigned(acc) + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    mag = $signed(q15[15:0]);
    return neg ? -mag : mag;
  endfunction

endpackage

/* rtl/core/fss_front.sv */
// Front end: configuration registers, input handshake and phase accumulator.
// Pushes one work item per accepted input into the queue. Depends on fss_pkg.
module fss_front import fss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  fss_in_t                  in_data_i,
  input  fss_qstat_t               qstat_i,
  output logic                     push_o,
  output fss_work_t                work_o
);

  logic [31:0] start_phase_q, start_phase_d;
  logic [15:0] step_size_q, step_size_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] advance;
  logic [31:0] phase;
  logic        in_fire;

  assign in_ready_o = !qstat_i.full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_o     = in_fire;

  always_comb begin
    start_phase_d = start_phase_q;
    step_size_d   = step_size_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgStartPhase: start_phase_d = cfg_data_i;
        CfgStepSize:   step_size_d   = cfg_data_i[15:0];
        default:       ;
      endcase
    end
  end

  assign advance = in_data_i.frequency * step_size_q;
  assign phase   = in_data_i.first ? start_phase_q : acc_q + advance;
  assign acc_d   = in_fire ? phase : acc_q;

  always_comb begin
    work_o.phase      = phase;
    work_o.background = in_data_i.background;
    work_o.amplitude  = in_data_i.amplitude;
    work_o.noise      = in_data_i.noise;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_phase_q <= '0;
      step_size_q   <= 16'd1;
      acc_q         <= '0;
    end else begin
      start_phase_q <= start_phase_d;
      step_size_q   <= step_size_d;
      acc_q         <= acc_d;
    end
  end

  a_first_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.first |=> acc_q == $past(start_phase_q))
    else $error("accumulator not loaded with start phase");

endmodule

/* rtl/core/fss_queue.sv */
// Two-entry work queue between front end and back end.
// Depends on fss_pkg.
module fss_queue import fss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fss_work_t  data_i,
  input  logic       pop_i,
  output fss_work_t  data_o,
  output fss_qstat_t stat_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fss_work_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign stat_o.valid = count_q != '0;
  assign stat_o.full  = count_q == CntW'(Depth);
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != CntW'(Depth))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

/* rtl/core/fss_back.sv */
// Back end: cosine ROM lookup, amplitude multiply, rounding, offset sum and
// saturation, ending in the output register. Depends on fss_pkg.
module fss_back import fss_pkg::*; #(
  parameter int unsigned TableBits = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fss_qstat_t qstat_i,
  input  fss_work_t  work_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output fss_out_t   out_data_o
);

  localparam int unsigned TableSize = 1 << TableBits;

  logic signed [15:0] cos_rom [TableSize];

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    assign cos_rom[k] = cos_turn(32'(k) << (32 - TableBits));
  end

  logic               en;
  logic               a_valid_q;
  logic               b_valid_q;
  logic               c_valid_q;
  fss_work_t          a_work_q;
  logic signed [15:0] a_cos_q;
  logic signed [31:0] b_prod_q;
  logic [31:0]        b_phase_q;
  logic signed [15:0] b_bg_q;
  logic signed [15:0] b_noise_q;
  fss_out_t           c_out_q;
  fss_out_t           c_out_d;
  logic signed [31:0] rounded;
  logic signed [16:0] scaled;
  logic signed [18:0] sum;

  assign en          = !c_valid_q || out_ready_i;
  assign pop_o       = qstat_i.valid && en;
  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_out_q;

  always_comb begin
    rounded = b_prod_q + 32'sd16384;
    scaled  = rounded[31:15];
    sum     = 19'(b_bg_q) + 19'(scaled) + 19'(b_noise_q);
    c_out_d.phase_now = b_phase_q;
    c_out_d.clipped   = 1'b0;
    c_out_d.sample    = sum[15:0];
    if (sum > 19'sd32767) begin
      c_out_d.sample  = 16'sh7FFF;
      c_out_d.clipped = 1'b1;
    end else if (sum < -19'sd32768) begin
      c_out_d.sample  = 16'sh8000;
      c_out_d.clipped = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_work_q  <= work_i;
      a_cos_q   <= cos_rom[work_i.phase[31 -: TableBits]];
      b_prod_q  <= $signed({1'b0, a_work_q.amplitude}) * a_cos_q;
      b_phase_q <= a_work_q.phase;
      b_bg_q    <= a_work_q.background;
      b_noise_q <= a_work_q.noise;
      c_out_q   <= c_out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= qstat_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && c_out_q.clipped |->
      c_out_q.sample == 16'sh7FFF || c_out_q.sample == 16'sh8000)
    else $error("clipped sample not at a rail");

endmodule

/* rtl/core/fringe_signal_synthesizer.sv */
// Fringe signal synthesizer: phase accumulator NCO with cosine ROM, gain and offset.
// Top level; instantiates fss_front, fss_queue and fss_back. Depends on fss_pkg.
//
// One input item gives one output item. The block takes one item per clock
// cycle when the output side keeps up; the phase accumulator update in the
// front end sets that figure. An accepted item passes through the queue, the
// ROM read register, the multiply register and the sum and saturate output
// register. The cosine ROM has 2^TableBits entries, fixed at elaboration, so
// no fill time follows reset. Configuration writes are taken in every cycle.
module fringe_signal_synthesizer import fss_pkg::*; #(
  parameter int unsigned TableBits = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  fss_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output fss_out_t                 out_data_o
);

  fss_qstat_t qstat;
  fss_work_t  push_work;
  fss_work_t  pop_work;
  logic       push;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  fss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .work_o      (push_work)
  );

  fss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_work),
    .pop_i  (pop),
    .data_o (pop_work),
    .stat_o (qstat)
  );

  fss_back #(
    .TableBits (TableBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .work_i      (pop_work),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
